// ----- src/atp_pkg.sv -----
// ----------------------------------------------------------------------------
// atp_pkg - shared types and constants for the animated test pattern source
// Pattern codes, reciprocal unit states, widths and the bar color table.
// ----------------------------------------------------------------------------
package atp_pkg;

  localparam int unsigned COORD_W      = 12;
  localparam int unsigned FRAME_W      = 24;
  localparam int unsigned LINE_WIDTH_W = 13;
  localparam int unsigned PIXEL_W      = 32;
  localparam int unsigned KIND_W       = 2;

  // Bar width is line_width / 8.
  localparam int unsigned BAR_W_W = LINE_WIDTH_W - 3;

  localparam int unsigned LINE_WIDTH_RESET = 640;
  localparam int unsigned BAR_W_RESET      = LINE_WIDTH_RESET / 8;

  // The bar reciprocal is floor(2^RECIP_SHIFT / bar width).
  localparam int unsigned RECIP_SHIFT = 28;
  localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;
  localparam int unsigned RECIP_RESET = (1 << RECIP_SHIFT) / BAR_W_RESET;

  // Scroll position x + 8f.
  localparam int unsigned SCROLL_W = FRAME_W + 4;

  // Pattern period is 60 frames; three patterns give a 180 frame cycle.
  // f mod 180 = 4 * ((f >> 2) mod 45) + f[1:0].
  localparam int unsigned FRAMES_PER_PATTERN = 60;
  localparam int unsigned DIV45            = 45;
  localparam int unsigned DIV45_SHIFT      = 28;
  localparam int unsigned DIV45_RECIP      = (1 << DIV45_SHIFT) / DIV45;
  localparam int unsigned DIV45_RECIP_W    = 23;
  localparam int unsigned FRAME_Q_W        = FRAME_W - 2;

  localparam logic [31:0] ARGB_WHITE = 32'hFFFF_FFFF;
  localparam logic [31:0] ARGB_BLACK = 32'hFF00_0000;
  localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;

  typedef enum logic [KIND_W-1:0] {
    PAT_GRADIENT = 2'd0,
    PAT_BARS     = 2'd1,
    PAT_CHECKER  = 2'd2
  } pattern_e;

  typedef enum logic {
    RCP_IDLE = 1'b0,
    RCP_RUN  = 1'b1
  } rcp_state_e;

  function automatic logic [PIXEL_W-1:0] bar_color(input logic [2:0] idx);
    logic [PIXEL_W-1:0] color;
    case (idx)
      3'd0:    color = 32'hFFFF_FFFF;
      3'd1:    color = 32'hFFFF_FF00;
      3'd2:    color = 32'hFF00_FFFF;
      3'd3:    color = 32'hFF00_FF00;
      3'd4:    color = 32'hFFFF_00FF;
      3'd5:    color = 32'hFFFF_0000;
      3'd6:    color = 32'hFF00_00FF;
      default: color = 32'hFF00_0000;
    endcase
    return color;
  endfunction

endpackage

// ----- src/animated_test_pattern_pixel.sv -----
// ----------------------------------------------------------------------------
// animated_test_pattern_pixel - animated ARGB test pattern pixel source
// Gradient, scrolling color bars and scrolling checkerboard, chosen by frame.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries column, row and frame
//   number; a request is taken when valid is high and stall is low. Output
//   channel (out_valid_o / out_stall_i) returns the pixel and its pattern code.
//   Configuration channel (cfg_valid_i / cfg_ready_o) writes line_width; write
//   it only while no request is in flight.
// Throughput:
//   Four register stages; one request is taken per cycle while neither an
//   output stall nor a rebuild holds it. The bar index uses a stored reciprocal
//   of the bar width; after each line_width write a bit-serial divider rebuilds
//   it, and during the rebuild cfg_ready_o is low and in_stall_o is high.
// Reset:
//   line_width is 640 with its reciprocal preloaded; the pipeline is empty.
// Stall:
//   Each stage advances when the next one is empty or moving, so bubbles
//   close up; a stalled result holds and in_stall_o rises once all four
//   stages are full.
// ----------------------------------------------------------------------------
module animated_test_pattern_pixel (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [atp_pkg::LINE_WIDTH_W-1:0]      line_width_i,
  // request
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [atp_pkg::COORD_W-1:0]           column_i,
  input  logic [atp_pkg::COORD_W-1:0]           row_i,
  input  logic [atp_pkg::FRAME_W-1:0]           frame_number_i,
  // result
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [atp_pkg::PIXEL_W-1:0]           argb_pixel_o,
  output logic [atp_pkg::KIND_W-1:0]            pattern_kind_o
);

  localparam int unsigned BW   = atp_pkg::BAR_W_W;
  localparam int unsigned RW   = atp_pkg::RECIP_W;
  localparam int unsigned SW   = atp_pkg::SCROLL_W;
  localparam int unsigned FQW  = atp_pkg::FRAME_Q_W;
  localparam int unsigned CNTW = $clog2(atp_pkg::RECIP_SHIFT + 1);
  localparam int unsigned BPW  = SW + RW;
  localparam int unsigned KPW  = FQW + atp_pkg::DIV45_RECIP_W;

  // --------------------------------------------------------------------------
  // Bar width register and bit-serial reciprocal unit
  // --------------------------------------------------------------------------
  atp_pkg::rcp_state_e state_q, state_d;
  logic [BW-1:0]       bw_q, bw_d;
  logic [RW-1:0]       recip_q, recip_d;
  logic [RW-1:0]       quot_q, quot_d;
  logic [BW-1:0]       rem_q, rem_d;
  logic [CNTW-1:0]     cnt_q, cnt_d;
  logic [BW:0]         trial;
  logic                qbit;
  logic [BW-1:0]       bw_new;

  assign bw_new = (line_width_i[atp_pkg::LINE_WIDTH_W-1:3] == '0) ?
                  BW'(1) : line_width_i[atp_pkg::LINE_WIDTH_W-1:3];

  always_comb begin
    state_d     = state_q;
    bw_d        = bw_q;
    recip_d     = recip_q;
    quot_d      = quot_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    cfg_ready_o = 1'b0;
    // Dividend is 2^RECIP_SHIFT: a single one bit at the top.
    trial = {rem_q, (cnt_q == CNTW'(atp_pkg::RECIP_SHIFT))};
    qbit  = (trial >= {1'b0, bw_q});
    case (state_q)
      atp_pkg::RCP_IDLE: begin
        cfg_ready_o = 1'b1;
        if (cfg_valid_i) begin
          bw_d    = bw_new;
          quot_d  = '0;
          rem_d   = '0;
          cnt_d   = CNTW'(atp_pkg::RECIP_SHIFT);
          state_d = atp_pkg::RCP_RUN;
        end
      end
      atp_pkg::RCP_RUN: begin
        rem_d  = qbit ? BW'(trial - {1'b0, bw_q}) : trial[BW-1:0];
        quot_d = {quot_q[RW-2:0], qbit};
        cnt_d  = cnt_q - CNTW'(1);
        if (cnt_q == '0) begin
          recip_d = {quot_q[RW-2:0], qbit};
          state_d = atp_pkg::RCP_IDLE;
        end
      end
      default: begin
        state_d = atp_pkg::RCP_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= atp_pkg::RCP_IDLE;
      bw_q    <= BW'(atp_pkg::BAR_W_RESET);
      recip_q <= RW'(atp_pkg::RECIP_RESET);
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      bw_q    <= bw_d;
      recip_q <= recip_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
  end

  // --------------------------------------------------------------------------
  // Pipeline flow control
  // --------------------------------------------------------------------------
  logic s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  logic s1_en, s2_en, s3_en, out_en;
  logic busy;
  logic in_accept;

  assign busy      = (state_q != atp_pkg::RCP_IDLE);
  assign out_en    = !out_valid_q || !out_stall_i;
  assign s3_en     = !s3_valid_q || out_en;
  assign s2_en     = !s2_valid_q || s3_en;
  assign s1_en     = !s1_valid_q || s2_en;
  assign in_stall_o = !s1_en || busy;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_en)  s1_valid_q  <= in_accept;
      if (s2_en)  s2_valid_q  <= s1_valid_q;
      if (s3_en)  s3_valid_q  <= s2_valid_q;
      if (out_en) out_valid_q <= s3_valid_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: gradient, checker parity, scroll position
  // --------------------------------------------------------------------------
  logic [7:0]  grad_off;
  logic [7:0]  grad_r, grad_g, grad_b;
  logic [6:0]  chk_off, chk_x, chk_y;
  logic [SW-1:0] scroll;

  assign grad_off = {frame_number_i[5:0], 2'b00};
  assign grad_r   = column_i[7:0] + grad_off;
  assign grad_g   = row_i[7:0] + grad_off;
  assign grad_b   = column_i[7:0] + row_i[7:0] + grad_off;
  // Square index parity is bit 6 of coordinate + 4f.
  assign chk_off  = {frame_number_i[4:0], 2'b00};
  assign chk_x    = column_i[6:0] + chk_off;
  assign chk_y    = row_i[6:0] + chk_off;
  assign scroll   = SW'(column_i) + {1'b0, frame_number_i, 3'b000};

  logic [23:0]   s1_grad_q;
  logic          s1_chk_q;
  logic [SW-1:0] s1_scroll_q;
  logic [FQW-1:0] s1_fq_q;
  logic [1:0]    s1_flo_q;

  always_ff @(posedge clk_i) begin
    if (s1_en) begin
      s1_grad_q   <= {grad_r, grad_g, grad_b};
      s1_chk_q    <= chk_x[6] ^ chk_y[6];
      s1_scroll_q <= scroll;
      s1_fq_q     <= frame_number_i[atp_pkg::FRAME_W-1:2];
      s1_flo_q    <= frame_number_i[1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: reciprocal multiplies, quotient estimates
  // --------------------------------------------------------------------------
  logic [BPW-1:0] bar_prod;
  logic [KPW-1:0] kind_prod;

  assign bar_prod  = BPW'(s1_scroll_q) * BPW'(recip_q);
  assign kind_prod = KPW'(s1_fq_q) * KPW'(atp_pkg::DIV45_RECIP);

  logic [BW:0]   s2_bq_q;
  logic [BW:0]   s2_nlo_q;
  logic [6:0]    s2_kq_q;
  logic [6:0]    s2_fqlo_q;
  logic [1:0]    s2_flo_q;
  logic [23:0]   s2_grad_q;
  logic          s2_chk_q;

  always_ff @(posedge clk_i) begin
    if (s2_en) begin
      // Only the low quotient bits matter: the remainder fits in BW+1 bits.
      s2_bq_q   <= bar_prod[atp_pkg::RECIP_SHIFT +: BW+1];
      s2_nlo_q  <= s1_scroll_q[BW:0];
      s2_kq_q   <= kind_prod[atp_pkg::DIV45_SHIFT +: 7];
      s2_fqlo_q <= s1_fq_q[6:0];
      s2_flo_q  <= s1_flo_q;
      s2_grad_q <= s1_grad_q;
      s2_chk_q  <= s1_chk_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: remainder check and quotient correction
  // --------------------------------------------------------------------------
  logic [2*BW+1:0] bar_mul;
  logic [BW:0]     bar_rem;
  logic [2:0]      bar_idx;
  logic [13:0]     kind_mul;
  logic [6:0]      kind_rem, kind_fix;

  assign bar_mul  = (2*BW+2)'(s2_bq_q) * (2*BW+2)'(bw_q);
  assign bar_rem  = s2_nlo_q - bar_mul[BW:0];
  assign bar_idx  = (bar_rem >= {1'b0, bw_q}) ? (s2_bq_q[2:0] + 3'd1) : s2_bq_q[2:0];
  assign kind_mul = 14'(s2_kq_q) * 14'(atp_pkg::DIV45);
  assign kind_rem = s2_fqlo_q - kind_mul[6:0];
  assign kind_fix = (kind_rem >= 7'(atp_pkg::DIV45)) ?
                    (kind_rem - 7'(atp_pkg::DIV45)) : kind_rem;

  logic [2:0]  s3_idx_q;
  logic [7:0]  s3_phase_q;
  logic [23:0] s3_grad_q;
  logic        s3_chk_q;

  always_ff @(posedge clk_i) begin
    if (s3_en) begin
      s3_idx_q   <= bar_idx;
      s3_phase_q <= {kind_fix[5:0], s2_flo_q};
      s3_grad_q  <= s2_grad_q;
      s3_chk_q   <= s2_chk_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: pattern select, output register
  // --------------------------------------------------------------------------
  atp_pkg::pattern_e    kind;
  logic [atp_pkg::PIXEL_W-1:0] pixel;

  always_comb begin
    if (s3_phase_q < 8'(atp_pkg::FRAMES_PER_PATTERN)) begin
      kind = atp_pkg::PAT_GRADIENT;
    end else if (s3_phase_q < 8'(2 * atp_pkg::FRAMES_PER_PATTERN)) begin
      kind = atp_pkg::PAT_BARS;
    end else begin
      kind = atp_pkg::PAT_CHECKER;
    end
    case (kind)
      atp_pkg::PAT_GRADIENT: pixel = {atp_pkg::ALPHA_OPAQUE, s3_grad_q};
      atp_pkg::PAT_BARS:     pixel = atp_pkg::bar_color(s3_idx_q);
      default:               pixel = s3_chk_q ? atp_pkg::ARGB_WHITE : atp_pkg::ARGB_BLACK;
    endcase
  end

  logic [atp_pkg::PIXEL_W-1:0] pixel_q;
  logic [atp_pkg::KIND_W-1:0]  kind_q;

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      pixel_q <= pixel;
      kind_q  <= kind;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign argb_pixel_o   = pixel_q;
  assign pattern_kind_o = kind_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  localparam logic [RW+BW:0] RECIP_ONE = (RW+BW+1)'(1) << atp_pkg::RECIP_SHIFT;

  a_no_request_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !in_accept)
    else $error("request accepted while the reciprocal is rebuilt");

  a_bar_width_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bw_q != '0)
    else $error("bar width register is zero");

  a_recip_exact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> (((RW+BW+1)'(recip_q) * (RW+BW+1)'(bw_q)) <= RECIP_ONE) &&
              (((RW+BW+1)'(recip_q) + (RW+BW+1)'(1)) * (RW+BW+1)'(bw_q) > RECIP_ONE))
    else $error("bar reciprocal does not match bar width");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pattern_kind_o == atp_pkg::PAT_GRADIENT) ||
                    (pattern_kind_o == atp_pkg::PAT_BARS) ||
                    (pattern_kind_o == atp_pkg::PAT_CHECKER))
    else $error("illegal pattern code on output");

  a_alpha_opaque: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> argb_pixel_o[31:24] == atp_pkg::ALPHA_OPAQUE)
    else $error("output pixel is not opaque");

endmodule

// ----- dv/animated_test_pattern_pixel_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// animated_test_pattern_pixel_test - pixel source testbench
// Sends column/row/frame requests under random idling on both channels and
// one long output hold, predicts each pixel and its pattern code, and checks
// results in order across line widths from zero up to the largest value.
// ----------------------------------------------------------------------------
module animated_test_pattern_pixel_test;

  localparam int unsigned COORD_W            = atp_pkg::COORD_W;
  localparam int unsigned FRAME_W            = atp_pkg::FRAME_W;
  localparam int unsigned PIXEL_W            = atp_pkg::PIXEL_W;
  localparam int unsigned KIND_W             = atp_pkg::KIND_W;
  localparam int unsigned LINE_WIDTH_W       = atp_pkg::LINE_WIDTH_W;
  localparam int unsigned FRAMES_PER_PATTERN = atp_pkg::FRAMES_PER_PATTERN;
  localparam int unsigned LINE_WIDTH_RESET   = atp_pkg::LINE_WIDTH_RESET;

  localparam int unsigned CLK_PERIOD       = 4;
  localparam int unsigned RESET_CYCLES     = 10;
  localparam int unsigned HOLD_CYCLES      = 200;
  localparam int unsigned DRAIN_CYCLES     = 8;
  localparam int unsigned MAX_REPORTS      = 10;
  localparam int unsigned NUM_PHASES       = 9;
  localparam int unsigned RANDOM_PER_PHASE = 65;
  localparam int unsigned PRESSURE_PHASE   = 3;
  localparam int unsigned SQUARE_LOG2      = 6;
  localparam int unsigned LAST_PERIOD      = (1 << FRAME_W) / FRAMES_PER_PATTERN;

  typedef struct packed {
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic [FRAME_W-1:0] frame;
  } request_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] argb;
    atp_pkg::pattern_e  kind;
  } pixel_t;

  logic                    clk_i          = 1'b0;
  logic                    rst_ni         = 1'b0;
  logic                    cfg_valid_i    = 1'b0;
  logic                    cfg_ready_o;
  logic [LINE_WIDTH_W-1:0] line_width_i   = '0;
  logic                    in_valid_i     = 1'b0;
  logic                    in_stall_o;
  logic [COORD_W-1:0]      column_i       = '0;
  logic [COORD_W-1:0]      row_i          = '0;
  logic [FRAME_W-1:0]      frame_number_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i    = 1'b0;
  logic [PIXEL_W-1:0]      argb_pixel_o;
  logic [KIND_W-1:0]       pattern_kind_o;

  request_t                pending_requests[$];
  pixel_t                  expected_pixels[$];
  request_t                next_request;
  pixel_t                  oldest_pixel;
  logic [LINE_WIDTH_W-1:0] line_width_q  = LINE_WIDTH_W'(LINE_WIDTH_RESET);
  bit                      idle_en       = 1'b1;
  int unsigned             gap_left      = 0;
  int unsigned             stall_left    = 0;
  int unsigned             hold_left     = 0;
  int unsigned             hold_requests = 0;
  int unsigned             holds_started = 0;
  int unsigned             mismatches    = 0;

  animated_test_pattern_pixel u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .line_width_i   (line_width_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .column_i       (column_i),
    .row_i          (row_i),
    .frame_number_i (frame_number_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .argb_pixel_o   (argb_pixel_o),
    .pattern_kind_o (pattern_kind_o)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  function automatic pixel_t predict_pixel(request_t req,
                                           logic [LINE_WIDTH_W-1:0] lw);
    pixel_t      px;
    logic [31:0] x, y, f, shift, bar_w, sx, sy;
    logic [2:0]  bar;
    x     = 32'(req.column);
    y     = 32'(req.row);
    f     = 32'(req.frame);
    shift = f << 2;
    px.kind = atp_pkg::pattern_e'(KIND_W'((f / FRAMES_PER_PATTERN) % 3));
    case (px.kind)
      atp_pkg::PAT_GRADIENT: begin
        sx = x + shift;
        sy = y + shift;
        px.argb = {atp_pkg::ALPHA_OPAQUE, sx[7:0], sy[7:0], 8'(x + y + shift)};
      end
      atp_pkg::PAT_BARS: begin
        // Saturate the bar width at one pixel for narrow lines.
        bar_w = 32'(lw) >> 3;
        if (bar_w == 0) bar_w = 1;
        bar = 3'((x + (f << 3)) / bar_w);
        // Red is off in bars 2,3,6,7, green in 4..7, blue in the odd bars.
        px.argb = {atp_pkg::ALPHA_OPAQUE, {8{~bar[1]}}, {8{~bar[2]}}, {8{~bar[0]}}};
      end
      default: begin
        sx = (x + shift) >> SQUARE_LOG2;
        sy = (y + shift) >> SQUARE_LOG2;
        px.argb = (sx[0] ^ sy[0]) ? atp_pkg::ARGB_WHITE : atp_pkg::ARGB_BLACK;
      end
    endcase
    return px;
  endfunction

  // Mostly back to back, some short gaps, a few long ones.
  function automatic int unsigned idle_len(bit en);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (!en || roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic request_t random_request();
    request_t    req;
    int unsigned roll;
    roll       = $urandom_range(0, 9);
    req.column = COORD_W'($urandom);
    req.row    = COORD_W'($urandom);
    req.frame  = FRAME_W'($urandom);
    if (roll < 2) begin
      // land next to a pattern change
      req.frame = FRAME_W'($urandom_range(0, LAST_PERIOD) * FRAMES_PER_PATTERN
                           + $urandom_range(0, 4) - 2);
    end else if (roll == 2) begin
      req.frame = FRAME_W'(24'hFF_FFFF - $urandom_range(0, 400));
    end else if (roll == 3) begin
      req.frame = FRAME_W'($urandom_range(0, 400));
    end
    return req;
  endfunction

  task automatic push_request(input int unsigned col, input int unsigned rw,
                              input int unsigned frm);
    pending_requests.push_back({COORD_W'(col), COORD_W'(rw), FRAME_W'(frm)});
  endtask

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    while (pending_requests.size() != 0 || in_valid_i || expected_pixels.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic write_line_width(input logic [LINE_WIDTH_W-1:0] lw);
    @(posedge clk_i);
    cfg_valid_i  <= 1'b1;
    line_width_i <= lw;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i  <= 1'b0;
    line_width_q = lw;
  endtask

  // Request driver: record the accepted request, then advance or idle.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o)
        expected_pixels.push_back(predict_pixel({column_i, row_i, frame_number_i},
                                                line_width_q));
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0 || pending_requests.size() == 0) begin
          if (gap_left != 0) gap_left--;
          in_valid_i <= 1'b0;
        end else begin
          next_request    = pending_requests.pop_front();
          column_i       <= next_request.column;
          row_i          <= next_request.row;
          frame_number_i <= next_request.frame;
          in_valid_i     <= 1'b1;
          gap_left        = idle_len(idle_en);
        end
      end
    end
  end

  // Long output hold, started on request from the sequence.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_started != hold_requests) begin
      hold_left     <= HOLD_CYCLES;
      holds_started <= holds_started + 1;
    end
  end

  // Result monitor: compare against the oldest prediction, then pick a stall.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_pixels.size() == 0) begin
          note_mismatch("unexpected result", 'x, argb_pixel_o);
        end else begin
          oldest_pixel = expected_pixels.pop_front();
          if (argb_pixel_o !== oldest_pixel.argb)
            note_mismatch("argb_pixel", oldest_pixel.argb, argb_pixel_o);
          if (pattern_kind_o !== oldest_pixel.kind)
            note_mismatch("pattern_kind", 32'(oldest_pixel.kind), 32'(pattern_kind_o));
        end
      end
      if (stall_left != 0) stall_left--;
      else stall_left = idle_len(idle_en);
      out_stall_i <= (stall_left != 0) || (hold_left != 0);
    end
  end

  initial begin
    int unsigned             phase, n;
    logic [LINE_WIDTH_W-1:0] lw;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Corners at the reset line width of 640.
    push_request(0, 0, 0);
    push_request(4095, 4095, 0);
    push_request(4095, 0, 59);
    push_request(0, 4095, 60);
    push_request(639, 0, 60);
    push_request(640, 0, 119);
    push_request(4095, 4095, 119);
    push_request(80, 0, 120);
    push_request(63, 64, 120);
    push_request(64, 63, 121);
    push_request(4095, 4095, 179);
    push_request(0, 0, 180);
    push_request(4095, 4095, 24'hFF_FFFF);
    push_request(0, 0, 24'hFF_FFFF);
    push_request(1, 2, 16777140);
    push_request(4095, 0, 16777080);
    push_request(2048, 2048, 24'h80_0000);
    push_request(2730, 1365, 24'hAA_AAAA);
    push_request(1365, 2730, 24'h55_5555);

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      wait_drained();
      case (phase)
        0:       lw = 13'd8;
        1:       lw = 13'd0;
        2:       lw = 13'd7;
        3:       lw = 13'd8191;
        4:       lw = 13'd4096;
        5:       lw = 13'd1;
        6:       lw = 13'd640;
        7:       lw = LINE_WIDTH_W'($urandom_range(8, 4096));
        default: lw = LINE_WIDTH_W'($urandom);
      endcase
      write_line_width(lw);
      @(negedge clk_i);
      // Some phases run with no idling on either side.
      idle_en = (phase != PRESSURE_PHASE) && (phase != 6);
      for (n = 0; n < RANDOM_PER_PHASE; n++)
        pending_requests.push_back(random_request());
      if (phase == PRESSURE_PHASE) hold_requests++;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
